@@ rtl/core/xosm_pkg.sv @@
// ----------------------------------------------------------------------------
// xosm_pkg
// constants for the xoshiro128+ generator with splitmix64 seeding
// ----------------------------------------------------------------------------
package xosm_pkg;

	localparam int FRACTION_BITS = 24;
	localparam int FRAC_SHIFT = (32 - FRACTION_BITS) % 32;

	localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] SM_MUL1   = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] SM_MUL2   = 64'h94d049bb133111eb;

	localparam int SM_SHIFT1 = 30;
	localparam int SM_SHIFT2 = 27;
	localparam int SM_SHIFT3 = 31;
	localparam int XO_SHL    = 9;
	localparam int XO_ROT    = 11;

	localparam logic [1:0] REQ_RAW  = 2'd0;
	localparam logic [1:0] REQ_FRAC = 2'd1;
	localparam logic [1:0] REQ_MOD  = 2'd2;

	localparam logic [1:0] MSTEP_LL = 2'd0;
	localparam logic [1:0] MSTEP_LH = 2'd1;
	localparam logic [1:0] MSTEP_HL = 2'd2;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ADD  = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_XOR  = 7'b0001000,
		ST_FOLD = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

endpackage

@@ rtl/core/xoshiro_prng_with_splitmix_seed.sv @@
// ----------------------------------------------------------------------------
// xoshiro_prng_with_splitmix_seed
// xoshiro128+ generator, seeded by four splitmix64 steps, with raw,
// fraction and bounded (modulo) result forms
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  req_type[1:0], bound[31:0]
//  res       out        res_valid/res_stall  value[31:0]
//  cfg       in         cfg_we               cfg_wdata[63:0] (seed)
//
//  seeding runs after reset or a seed write (per word: one add, two passes of the
//  LL, LH and HL partial products on the shared 32x32 multiplier, each with a mix, then a fold)
//  raw, fraction and zero-bound requests go straight from idle to done; a bounded
//  request first runs the radix-2 remainder loop on the shared 33-bit subtractor
//  req_stall is high while seeding or working on a beat; a finished result
//  waits in the output register while the next beat is accepted
// ----------------------------------------------------------------------------
module xoshiro_prng_with_splitmix_seed (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] bound,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] value
);

	xosm_pkg::state_t state_q;

	logic [31:0] words_q [4];
	logic [63:0] acc_q;
	logic [63:0] z_q;
	logic [31:0] lo_q;
	logic [31:0] hi_q;
	logic [1:0]  mstep_q;
	logic        round_q;
	logic [1:0]  widx_q;
	logic [31:0] dvd_q;
	logic [31:0] div_q;
	logic [31:0] rem_q;
	logic [4:0]  cnt_q;
	logic [31:0] result_q;
	logic        res_valid_q;
	logic [31:0] value_q;

	logic [63:0] acc_next;
	logic [63:0] mix1;
	logic [63:0] mixed;
	logic [63:0] mix2;
	logic [63:0] mix3;
	logic [31:0] fold;
	logic [63:0] mconst;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [31:0] sum;
	logic [31:0] adv_w0;
	logic [31:0] adv_w1;
	logic [31:0] adv_w2;
	logic [31:0] adv_w3;
	logic [31:0] x3;
	logic [32:0] trial;
	logic [32:0] trial_sub;
	logic [31:0] rem_next;
	logic        out_free;
	logic        res_load;
	logic        req_acc;

	// splitmix datapath
	assign acc_next = acc_q + xosm_pkg::SM_GOLDEN;
	assign mix1     = acc_next ^ (acc_next >> xosm_pkg::SM_SHIFT1);
	assign mixed    = {hi_q, lo_q};
	assign mix2     = mixed ^ (mixed >> xosm_pkg::SM_SHIFT2);
	assign mix3     = mixed ^ (mixed >> xosm_pkg::SM_SHIFT3);
	assign fold     = mix3[63:32] ^ mix3[31:0];
	assign mconst   = round_q ? xosm_pkg::SM_MUL2 : xosm_pkg::SM_MUL1;

	// shared multiplier
	assign mul_a = (mstep_q == xosm_pkg::MSTEP_HL) ? z_q[63:32] : z_q[31:0];
	assign mul_b = (mstep_q == xosm_pkg::MSTEP_LH) ? mconst[63:32] : mconst[31:0];
	assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

	// xoshiro128+ step
	assign sum    = words_q[0] + words_q[3];
	assign adv_w2 = words_q[2] ^ words_q[0] ^ (words_q[1] << xosm_pkg::XO_SHL);
	assign x3     = words_q[3] ^ words_q[1];
	assign adv_w1 = words_q[1] ^ words_q[2] ^ words_q[0];
	assign adv_w0 = words_q[0] ^ x3;
	assign adv_w3 = {x3[31-xosm_pkg::XO_ROT:0], x3[31:32-xosm_pkg::XO_ROT]};

	// shared subtractor for the remainder loop
	assign trial     = {rem_q, dvd_q[31]};
	assign trial_sub = trial - {1'b0, div_q};
	assign rem_next  = trial_sub[32] ? trial[31:0] : trial_sub[31:0];

	assign out_free  = !res_valid_q || !res_stall;
	assign res_load  = (state_q == xosm_pkg::ST_DONE) && out_free && !cfg_we;
	assign req_stall = (state_q != xosm_pkg::ST_IDLE);
	assign req_acc   = req_valid && (state_q == xosm_pkg::ST_IDLE);
	assign res_valid = res_valid_q;
	assign value     = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xosm_pkg::ST_ADD;
			acc_q       <= 64'd0;
			mstep_q     <= xosm_pkg::MSTEP_LL;
			round_q     <= 1'b0;
			widx_q      <= 2'd0;
			cnt_q       <= 5'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				acc_q   <= cfg_wdata;
				mstep_q <= xosm_pkg::MSTEP_LL;
				round_q <= 1'b0;
				widx_q  <= 2'd0;
				state_q <= xosm_pkg::ST_ADD;
			end else begin
				case (state_q)
					xosm_pkg::ST_IDLE: begin
						if (req_valid) begin
							if (req_type == xosm_pkg::REQ_MOD && bound != 32'd0) begin
								cnt_q   <= 5'd0;
								state_q <= xosm_pkg::ST_DIV;
							end else begin
								state_q <= xosm_pkg::ST_DONE;
							end
						end
					end
					xosm_pkg::ST_ADD: begin
						acc_q   <= acc_next;
						mstep_q <= xosm_pkg::MSTEP_LL;
						state_q <= xosm_pkg::ST_MUL;
					end
					xosm_pkg::ST_MUL: begin
						if (mstep_q == xosm_pkg::MSTEP_HL) begin
							state_q <= xosm_pkg::ST_XOR;
						end
						mstep_q <= mstep_q + 2'd1;
					end
					xosm_pkg::ST_XOR: begin
						mstep_q <= xosm_pkg::MSTEP_LL;
						if (round_q) begin
							state_q <= xosm_pkg::ST_FOLD;
						end else begin
							round_q <= 1'b1;
							state_q <= xosm_pkg::ST_MUL;
						end
					end
					xosm_pkg::ST_FOLD: begin
						round_q <= 1'b0;
						widx_q  <= widx_q + 2'd1;
						state_q <= (widx_q == 2'd3) ? xosm_pkg::ST_IDLE : xosm_pkg::ST_ADD;
					end
					xosm_pkg::ST_DIV: begin
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == 5'd31) begin
							state_q <= xosm_pkg::ST_DONE;
						end
					end
					xosm_pkg::ST_DONE: begin
						if (out_free) begin
							state_q <= xosm_pkg::ST_IDLE;
						end
					end
					default: begin
						state_q <= xosm_pkg::ST_IDLE;
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			xosm_pkg::ST_ADD: begin
				z_q <= mix1;
			end
			xosm_pkg::ST_MUL: begin
				case (mstep_q)
					xosm_pkg::MSTEP_LL: begin
						lo_q <= prod[31:0];
						hi_q <= prod[63:32];
					end
					default: begin
						hi_q <= hi_q + prod[31:0];
					end
				endcase
			end
			xosm_pkg::ST_XOR: begin
				z_q <= mix2;
			end
			xosm_pkg::ST_FOLD: begin
				words_q[widx_q] <= fold;
				if (widx_q == 2'd3 &&
				    (words_q[0] | words_q[1] | words_q[2] | fold) == 32'd0) begin
					words_q[0] <= 32'd1;
				end
			end
			xosm_pkg::ST_DIV: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[30:0], 1'b0};
				if (cnt_q == 5'd31) begin
					result_q <= rem_next;
				end
			end
			xosm_pkg::ST_DONE: begin
				if (out_free) begin
					value_q <= result_q;
				end
			end
			default: begin
			end
		endcase
		if (req_acc && !cfg_we) begin
			case (req_type)
				xosm_pkg::REQ_RAW: begin
					result_q <= sum;
				end
				xosm_pkg::REQ_FRAC: begin
					result_q <= sum >> xosm_pkg::FRAC_SHIFT;
				end
				xosm_pkg::REQ_MOD: begin
					result_q <= 32'd0;
					dvd_q    <= sum;
					div_q    <= bound;
					rem_q    <= 32'd0;
				end
				default: begin
					result_q <= 32'd0;
				end
			endcase
			if (req_type == xosm_pkg::REQ_RAW || req_type == xosm_pkg::REQ_FRAC ||
			    (req_type == xosm_pkg::REQ_MOD && bound != 32'd0)) begin
				words_q[0] <= adv_w0;
				words_q[1] <= adv_w1;
				words_q[2] <= adv_w2;
				words_q[3] <= adv_w3;
			end
		end
	end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the xoshiro128+ generator with splitmix64 seeding:
// an in-bench predictor follows every seed write and every accepted request,
// and each result beat is compared with the oldest predicted value
// ----------------------------------------------------------------------------
module tb;

	localparam logic [1:0] REQ_UNDEF = 2'd3;
	localparam int SEED_PAUSE = 4;
	localparam int END_PAUSE = 40;
	localparam int RANDOM_ITEMS = 228;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [63:0] cfg_wdata;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  req_type;
	logic [31:0] bound;
	logic        res_valid;
	logic        res_stall;
	logic [31:0] value;

	int send_idle_pct;
	int recv_idle_pct;
	int mismatch_count = 0;

	logic [31:0] gen_words [4];
	logic [31:0] expected_values [$];

	xoshiro_prng_with_splitmix_seed dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.bound     (bound),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.value     (value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// four splitmix64 steps, each folded to one generator word
	function automatic void load_seed_words(input logic [63:0] s);
		logic [63:0] acc;
		logic [63:0] z;
		acc = s;
		for (int i = 0; i < 4; i++) begin
			acc = acc + xosm_pkg::SM_GOLDEN;
			z = acc;
			z = (z ^ (z >> xosm_pkg::SM_SHIFT1)) * xosm_pkg::SM_MUL1;
			z = (z ^ (z >> xosm_pkg::SM_SHIFT2)) * xosm_pkg::SM_MUL2;
			z = z ^ (z >> xosm_pkg::SM_SHIFT3);
			gen_words[i] = z[31:0] ^ z[63:32];
		end
		if ((gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) == 32'd0) begin
			gen_words[0] = 32'd1;
		end
	endfunction

	function automatic logic [31:0] advance_words();
		logic [31:0] sum;
		logic [31:0] t;
		sum = gen_words[0] + gen_words[3];
		t = gen_words[1] << xosm_pkg::XO_SHL;
		gen_words[2] = gen_words[2] ^ gen_words[0];
		gen_words[3] = gen_words[3] ^ gen_words[1];
		gen_words[1] = gen_words[1] ^ gen_words[2];
		gen_words[0] = gen_words[0] ^ gen_words[3];
		gen_words[2] = gen_words[2] ^ t;
		gen_words[3] = (gen_words[3] << xosm_pkg::XO_ROT) |
			(gen_words[3] >> (32 - xosm_pkg::XO_ROT));
		return sum;
	endfunction

	function automatic logic [31:0] predict_value(input logic [1:0] kind,
			input logic [31:0] lim);
		case (kind)
			xosm_pkg::REQ_RAW: return advance_words();
			xosm_pkg::REQ_FRAC: return advance_words() >> xosm_pkg::FRAC_SHIFT;
			xosm_pkg::REQ_MOD: begin
				if (lim != 32'd0) begin
					return advance_words() % lim;
				end
				return 32'd0;
			end
			default: return 32'd0;
		endcase
	endfunction

	task automatic send_req(input logic [1:0] kind, input logic [31:0] lim);
		logic [31:0] exp_value;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		bound <= lim;
		do @(posedge clk); while (req_stall);
		exp_value = predict_value(kind, lim);
		expected_values = {expected_values, exp_value};
	endtask

	task automatic wait_idle(input int pause);
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_values.size() != 0) @(posedge clk);
		repeat (pause) @(posedge clk);
	endtask

	task automatic write_seed(input logic [63:0] s);
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		load_seed_words(s);
	endtask

	task automatic test_raw_and_fraction();
		send_req(xosm_pkg::REQ_RAW, 32'd0);
		send_req(xosm_pkg::REQ_RAW, 32'hFFFF_FFFF);
		send_req(xosm_pkg::REQ_FRAC, 32'd0);
		send_req(xosm_pkg::REQ_FRAC, 32'hFFFF_FFFF);
	endtask

	task automatic test_bounded();
		send_req(xosm_pkg::REQ_MOD, 32'd0);
		send_req(xosm_pkg::REQ_MOD, 32'd1);
		send_req(xosm_pkg::REQ_MOD, 32'd2);
		send_req(xosm_pkg::REQ_MOD, 32'd3);
		send_req(xosm_pkg::REQ_MOD, 32'h8000_0000);
		send_req(xosm_pkg::REQ_MOD, 32'hFFFF_FFFF);
		send_req(xosm_pkg::REQ_MOD, 32'd0);
	endtask

	task automatic test_undefined_type();
		send_req(REQ_UNDEF, 32'd0);
		send_req(REQ_UNDEF, 32'hFFFF_FFFF);
		send_req(xosm_pkg::REQ_RAW, 32'd5);
	endtask

	task automatic test_seed_extremes();
		logic [63:0] seeds [4];
		seeds = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd1, 64'h8000_0000_0000_0000};
		foreach (seeds[i]) begin
			wait_idle(SEED_PAUSE);
			write_seed(seeds[i]);
			send_req(xosm_pkg::REQ_RAW, 32'd0);
			send_req(xosm_pkg::REQ_MOD, 32'hFFFF_FFFE);
		end
	endtask

	task automatic test_random_traffic(input int n_items);
		logic [63:0] s;
		logic [31:0] lim;
		logic [1:0]  kind;
		int pick;
		for (int g = 0; g < 4; g++) begin
			pick = $urandom_range(0, 7);
			case (pick)
				0: s = 64'd0;
				1: s = 64'hFFFF_FFFF_FFFF_FFFF;
				2: s = 64'($urandom_range(0, 255));
				default: s = {$urandom, $urandom};
			endcase
			wait_idle(SEED_PAUSE);
			write_seed(s);
			for (int i = 0; i < n_items / 4; i++) begin
				pick = $urandom_range(0, 19);
				kind = (pick == 0) ? REQ_UNDEF : 2'(pick % 3);
				case ($urandom_range(0, 9))
					0: lim = 32'd0;
					1, 2, 3: lim = $urandom_range(1, 16);
					4: lim = 32'd1 << $urandom_range(0, 31);
					5: lim = 32'hFFFF_FFFF - $urandom_range(0, 15);
					default: lim = $urandom;
				endcase
				send_req(kind, lim);
			end
		end
	endtask

	always @(posedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_values.size() == 0) begin
				$error("value: expected none, actual %h", value);
				mismatch_count++;
			end else begin
				if (value !== expected_values[0]) begin
					$error("value: expected %h, actual %h", expected_values[0], value);
					mismatch_count++;
				end
				void'(expected_values.pop_front());
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 64'd0;
		req_valid <= 1'b0;
		req_type <= xosm_pkg::REQ_RAW;
		bound <= 32'd0;
		res_stall <= 1'b0;
		send_idle_pct = 15;
		recv_idle_pct = 79;
		load_seed_words(64'd0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_raw_and_fraction();
		test_bounded();
		test_undefined_type();
		test_seed_extremes();
		test_random_traffic(RANDOM_ITEMS);

		wait_idle(SEED_PAUSE);
		send_idle_pct = 79;
		recv_idle_pct = 15;
		test_random_traffic(RANDOM_ITEMS);

		wait_idle(SEED_PAUSE);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(RANDOM_ITEMS);

		wait_idle(END_PAUSE);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/xosm_pkg.sv
rtl/core/xoshiro_prng_with_splitmix_seed.sv
sim/tb.sv
